@@ hdl/msbp_pkg.sv @@
package msbp_pkg;

    typedef enum logic [0:0] {
        CMD_WRITE = 1'b0,
        CMD_FLUSH = 1'b1
    } pack_cmd_t;

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_EMIT
    } ctrl_state_t;

    typedef struct packed {
        logic load;
        logic emit;
    } dp_cmd_t;

    typedef struct packed {
        logic has_word;
        logic out_free;
    } dp_status_t;

endpackage

@@ hdl/msbp_ctrl.sv @@
module msbp_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  msbp_pkg::dp_status_t status,
    output msbp_pkg::dp_cmd_t    cmd
);
    import msbp_pkg::*;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        s_ready    = 1'b0;
        cmd        = '0;
        case (state_reg)
            ST_IDLE: begin
                s_ready  = 1'b1;
                cmd.load = s_valid;
                if (s_valid) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (!status.has_word) begin
                    state_next = ST_IDLE;
                end else begin
                    cmd.emit = status.out_free;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    a_load_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load |-> (state_reg == ST_IDLE))
        else $error("load outside idle");

    a_idle_drained: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |-> !status.has_word)
        else $error("idle with a full word held");

    a_emit_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |-> (status.out_free && status.has_word))
        else $error("emit into busy output register");

endmodule

@@ hdl/msbp_datapath.sv @@
module msbp_datapath #(
    parameter int WORD_BITS      = 8,
    parameter int MAX_FIELD_BITS = 32
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_cmd,
    input  logic [5:0]           s_num_bits,
    input  logic [31:0]          s_value,
    output logic [7:0]           m_out_byte,
    output logic                 m_last,
    output logic                 m_valid,
    input  logic                 m_ready,
    input  msbp_pkg::dp_cmd_t    cmd,
    output msbp_pkg::dp_status_t status
);
    import msbp_pkg::*;

    localparam int ACC_W = WORD_BITS - 1 + MAX_FIELD_BITS;
    localparam int CNT_W = $clog2(2 * WORD_BITS + MAX_FIELD_BITS);
    localparam int NW    = $clog2(MAX_FIELD_BITS + 1);
    localparam logic [ACC_W-1:0] ONES = '1;

    logic [ACC_W-1:0] acc_reg, acc_next;
    logic [CNT_W-1:0] total_reg, total_next;
    logic [7:0]       out_byte_reg, out_byte_next;
    logic             last_reg, last_next;
    logic             m_valid_reg, m_valid_next;

    logic [ACC_W-1:0] pend;
    logic [ACC_W-1:0] word;
    logic [NW-1:0]    n_sat;
    logic [31:0]      vmask;
    logic [CNT_W-1:0] sh;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            total_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            total_reg   <= total_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        acc_reg      <= acc_next;
        out_byte_reg <= out_byte_next;
        last_reg     <= last_next;
    end

    always_comb begin
        pend = acc_reg & (ONES >> (CNT_W'(ACC_W) - total_reg));
        if (s_num_bits > 6'(MAX_FIELD_BITS)) begin
            n_sat = NW'(MAX_FIELD_BITS);
        end else begin
            n_sat = NW'(s_num_bits);
        end
        vmask = s_value & ~(32'hffff_ffff << n_sat);
        sh    = total_reg - CNT_W'(WORD_BITS);
        word  = acc_reg >> sh;

        acc_next      = acc_reg;
        total_next    = total_reg;
        out_byte_next = out_byte_reg;
        last_next     = last_reg;
        m_valid_next  = m_valid_reg && !m_ready;

        if (cmd.load) begin
            if (s_cmd == CMD_FLUSH) begin
                if (total_reg != '0) begin
                    acc_next   = acc_reg << (CNT_W'(WORD_BITS) - total_reg);
                    total_next = CNT_W'(WORD_BITS);
                end
            end else begin
                acc_next   = (pend << n_sat) | ACC_W'(vmask);
                total_next = total_reg + CNT_W'(n_sat);
            end
        end

        if (cmd.emit) begin
            out_byte_next = word[7:0];
            last_next     = total_reg < CNT_W'(2 * WORD_BITS);
            total_next    = sh;
            m_valid_next  = 1'b1;
        end
    end

    assign status.has_word = total_reg >= CNT_W'(WORD_BITS);
    assign status.out_free = !m_valid_reg || m_ready;

    assign m_out_byte = out_byte_reg;
    assign m_last     = last_reg;
    assign m_valid    = m_valid_reg;

    a_emit_full: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |-> (total_reg >= CNT_W'(WORD_BITS)))
        else $error("emit without a full word");

    a_emit_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |=> m_valid_reg)
        else $error("emitted beat not presented");

    a_total_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        total_reg <= CNT_W'(ACC_W))
        else $error("bit count overflow");

endmodule

@@ hdl/msb_first_bit_packer_core.sv @@
// MSB-first bit packer: write beats append the low num_bits bits of value (num_bits above
// MAX_FIELD_BITS saturates) and every completed WORD_BITS word leaves as one beat on the
// m_ side, earliest bit in the MSB, low 8 bits of the word on m_out_byte, m_last on the final
// beat of each input item. A flush beat emits the pending partial word padded with zeros and
// empties the buffer; a flush with nothing pending, or a write that fills no word, gives no
// beat. One item at a time: an input beat is loaded, then the emit loop extracts each word
// through the output register, one word per cycle while m_ready allows (it stalls while
// m_ready is low with a beat held), then returns to idle once no full word is left.
module msb_first_bit_packer_core #(
    parameter int WORD_BITS      = 8,
    parameter int MAX_FIELD_BITS = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_cmd,
    input  logic [5:0]  s_num_bits,
    input  logic [31:0] s_value,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_out_byte,
    output logic        m_last
);
    import msbp_pkg::*;

    dp_cmd_t    dp_cmd;
    dp_status_t dp_status;

    msbp_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (dp_status),
        .cmd     (dp_cmd)
    );

    msbp_datapath #(
        .WORD_BITS      (WORD_BITS),
        .MAX_FIELD_BITS (MAX_FIELD_BITS)
    ) u_datapath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_cmd      (s_cmd),
        .s_num_bits (s_num_bits),
        .s_value    (s_value),
        .m_out_byte (m_out_byte),
        .m_last     (m_last),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .cmd        (dp_cmd),
        .status     (dp_status)
    );

endmodule
